[design/ps2mt_pkg.sv]
// Shared types, constants and helpers of the PS/2 mouse packet tracker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ps2mt_pkg;

    localparam int CoordWidth = 12;
    localparam int PtrWidth   = 12;
    localparam int LimWidth   = 13;
    localparam int SumWidth   = 18;

    localparam logic [7:0] SyncBit  = 8'h08;
    localparam logic [7:0] XSignBit = 8'h10;
    localparam logic [7:0] YSignBit = 8'h20;
    localparam logic [7:0] OvfBits  = 8'hC0;
    localparam logic [7:0] LeftBit  = 8'h01;
    localparam logic [7:0] RightBit = 8'h02;

    localparam logic [CoordWidth-1:0] ResetX = CoordWidth'(320);
    localparam logic [CoordWidth-1:0] ResetY = CoordWidth'(240);

    typedef logic [CoordWidth-1:0] t_coord;

    typedef enum logic [1:0] {
        EvDown   = 2'd0,
        EvUp     = 2'd1,
        EvScroll = 2'd2,
        EvMove   = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        PosHeader = 2'd0,
        PosX      = 2'd1,
        PosY      = 2'd2,
        PosScroll = 2'd3
    } t_pos;

    typedef enum logic [1:0] {
        RegWheelMode   = 2'd0,
        RegWidthLimit  = 2'd1,
        RegHeightLimit = 2'd2,
        RegSpeedFactor = 2'd3
    } t_reg;

    typedef struct packed {
        logic                wheel_mode;
        logic [LimWidth-1:0] width_limit;
        logic [LimWidth-1:0] height_limit;
        logic [1:0]          speed_factor;
    } t_cfg;

    // One completed, non-overflowed packet with scaled deltas.
    typedef struct packed {
        logic               left;
        logic               right;
        logic signed [10:0] dx;
        logic signed [10:0] dy;
        logic signed [2:0]  wz;
    } t_pkt;

    // Multiply by speed (0 acts as 1) and halve, truncating toward zero.
    function automatic logic signed [10:0] scale_delta(input logic signed [9:0] d,
                                                       input logic [1:0] sp);
        logic [1:0]         spe;
        logic signed [11:0] p;
        logic signed [11:0] p_adj;
        spe   = (sp == 2'd0) ? 2'd1 : sp;
        p     = 12'(d) * $signed({10'd0, spe});
        p_adj = p + $signed({11'd0, p[11]});
        return p_adj[11:1];
    endfunction

    // Fold scroll byte: beyond +-7 becomes +-1, then clamp to +-3.
    function automatic logic signed [2:0] fold_scroll(input logic [7:0] b);
        logic signed [7:0] z;
        logic signed [2:0] r;
        z = $signed(b);
        if (z > 8'sd7) begin
            r = 3'sd1;
        end else if (z < -8'sd7) begin
            r = -3'sd1;
        end else if (z > 8'sd3) begin
            r = 3'sd3;
        end else if (z < -8'sd3) begin
            r = -3'sd3;
        end else begin
            r = z[2:0];
        end
        return r;
    endfunction

    // Limit 0 acts as 1, limits above 2^CoordWidth act as 2^CoordWidth.
    function automatic logic [16:0] eff_limit(input logic [LimWidth-1:0] lim);
        logic [16:0] l;
        logic [16:0] top;
        l   = 17'(lim);
        top = 17'(1) << CoordWidth;
        if (l == 17'd0) begin
            l = 17'd1;
        end else if (l > top) begin
            l = top;
        end
        return l;
    endfunction

    function automatic t_coord clamp_coord(input t_coord cur,
                                           input logic signed [10:0] d,
                                           input logic [LimWidth-1:0] lim);
        logic signed [SumWidth-1:0] v;
        logic [16:0]                l;
        t_coord                     r;
        l = eff_limit(lim);
        v = $signed({{(SumWidth-CoordWidth){1'b0}}, cur}) + SumWidth'(d);
        if (v[SumWidth-1]) begin
            r = '0;
        end else if (v[16:0] >= l) begin
            r = CoordWidth'(l - 17'd1);
        end else begin
            r = v[CoordWidth-1:0];
        end
        return r;
    endfunction

    function automatic logic [PtrWidth-1:0] to_ptr(input t_coord c);
        logic [CoordWidth+PtrWidth-1:0] t;
        t = (CoordWidth+PtrWidth)'(c);
        return t[PtrWidth-1:0];
    endfunction

endpackage

`default_nettype wire

[design/ps2mt_front.sv]
// Front end: assembles mouse bytes into packets, drops unsynced and
// overflowed ones, scales deltas and folds scroll. Uses ps2mt_pkg.
`default_nettype none

module ps2mt_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_rx_byte,
    input  wire ps2mt_pkg::t_cfg   i_cfg,
    output logic                   o_push,
    output ps2mt_pkg::t_pkt        o_pkt,
    input  wire logic              i_full
);

    ps2mt_pkg::t_pos r_pos, n_pos;
    logic [7:0]      r_hdr, n_hdr;
    logic [7:0]      r_xb, n_xb;
    logic [7:0]      r_yb, n_yb;

    logic              acc;
    logic              complete;
    logic              use_scroll;
    logic [7:0]        ybyte;
    logic signed [9:0] dx_raw;
    logic signed [9:0] dy_raw;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;

    always_comb begin
        n_pos    = r_pos;
        n_hdr    = r_hdr;
        n_xb     = r_xb;
        n_yb     = r_yb;
        complete = 1'b0;
        if (acc) begin
            case (r_pos)
                ps2mt_pkg::PosHeader: begin
                    if ((i_rx_byte & ps2mt_pkg::SyncBit) != 8'd0) begin
                        n_hdr = i_rx_byte;
                        n_pos = ps2mt_pkg::PosX;
                    end
                end
                ps2mt_pkg::PosX: begin
                    n_xb  = i_rx_byte;
                    n_pos = ps2mt_pkg::PosY;
                end
                ps2mt_pkg::PosY: begin
                    n_yb = i_rx_byte;
                    if (i_cfg.wheel_mode) begin
                        n_pos = ps2mt_pkg::PosScroll;
                    end else begin
                        n_pos    = ps2mt_pkg::PosHeader;
                        complete = 1'b1;
                    end
                end
                ps2mt_pkg::PosScroll: begin
                    n_pos    = ps2mt_pkg::PosHeader;
                    complete = 1'b1;
                end
                default: begin
                    n_pos = ps2mt_pkg::PosHeader;
                end
            endcase
        end
    end

    // The y byte is still on the input when a three-byte packet completes.
    assign ybyte      = (r_pos == ps2mt_pkg::PosY) ? i_rx_byte : r_yb;
    assign use_scroll = (r_pos == ps2mt_pkg::PosScroll) && i_cfg.wheel_mode;

    assign dx_raw = $signed({{2{(r_hdr & ps2mt_pkg::XSignBit) != 8'd0}}, r_xb});
    assign dy_raw = -$signed({{2{(r_hdr & ps2mt_pkg::YSignBit) != 8'd0}}, ybyte});

    always_comb begin
        o_pkt.left  = (r_hdr & ps2mt_pkg::LeftBit) != 8'd0;
        o_pkt.right = (r_hdr & ps2mt_pkg::RightBit) != 8'd0;
        o_pkt.dx    = ps2mt_pkg::scale_delta(dx_raw, i_cfg.speed_factor);
        o_pkt.dy    = ps2mt_pkg::scale_delta(dy_raw, i_cfg.speed_factor);
        o_pkt.wz    = use_scroll ? ps2mt_pkg::fold_scroll(i_rx_byte) : 3'sd0;
    end

    // Drop overflowed packets here; they leave no trace downstream.
    assign o_push = complete && ((r_hdr & ps2mt_pkg::OvfBits) == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= ps2mt_pkg::PosHeader;
            r_hdr <= 8'd0;
            r_xb  <= 8'd0;
            r_yb  <= 8'd0;
        end else begin
            r_pos <= n_pos;
            r_hdr <= n_hdr;
            r_xb  <= n_xb;
            r_yb  <= n_yb;
        end
    end

endmodule

`default_nettype wire

[design/ps2mt_fifo.sv]
// Two-entry packet queue between front and back end.
// Uses ps2mt_pkg for the packet type.
`default_nettype none

module ps2mt_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ps2mt_pkg::t_pkt i_pkt,
    output logic                 o_full,
    input  wire logic            i_pop,
    output ps2mt_pkg::t_pkt      o_pkt,
    output logic                 o_empty
);

    ps2mt_pkg::t_pkt r_mem [2];
    logic            r_wp, n_wp;
    logic            r_rp, n_rp;
    logic [1:0]      r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_pkt   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = !r_wp;
        end
        if (i_pop) begin
            n_rp = !r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[design/ps2mt_back.sv]
// Back end: applies a packet to cursor and button state, then issues its
// events one beat at a time through an output register. Uses ps2mt_pkg.
`default_nettype none

module ps2mt_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ps2mt_pkg::t_cfg i_cfg,
    input  wire ps2mt_pkg::t_pkt i_pkt,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [1:0]           o_event_kind,
    output logic [1:0]           o_button_code,
    output logic [11:0]          o_pointer_x,
    output logic [11:0]          o_pointer_y,
    output logic signed [2:0]    o_wheel_delta,
    output logic                 o_last_of_packet
);

    ps2mt_pkg::t_coord r_cx, r_cy;
    logic              r_left, r_right;
    logic [3:0]        r_pend, n_pend;
    logic signed [2:0] r_wz;

    logic              r_ov, n_ov;
    ps2mt_pkg::t_event r_kind, n_kind;
    logic [1:0]        r_code, n_code;
    logic [11:0]       r_px, r_py;
    logic signed [2:0] r_owz, n_owz;
    logic              r_last, n_last;

    logic       emit;
    logic [3:0] sel;
    logic [3:0] rest;

    // Pending bits: left edge, right edge, scroll, move; lowest goes first.
    assign sel   = r_pend & (~r_pend + 4'd1);
    assign rest  = r_pend & ~sel;
    assign emit  = (r_pend != 4'd0) && (!r_ov || !i_stall);
    assign o_pop = !i_empty && ((r_pend == 4'd0) || (emit && rest == 4'd0));

    always_comb begin
        n_kind = r_kind;
        n_code = r_code;
        n_owz  = 3'sd0;
        n_last = rest == 4'd0;
        case (sel)
            4'b0001: begin
                n_kind = r_left ? ps2mt_pkg::EvDown : ps2mt_pkg::EvUp;
                n_code = 2'd0;
            end
            4'b0010: begin
                n_kind = r_right ? ps2mt_pkg::EvDown : ps2mt_pkg::EvUp;
                n_code = 2'd1;
            end
            4'b0100: begin
                n_kind = ps2mt_pkg::EvScroll;
                n_code = 2'd0;
                n_owz  = r_wz;
            end
            4'b1000: begin
                n_kind = ps2mt_pkg::EvMove;
                n_code = {r_right, r_left};
            end
            default: begin
                n_kind = r_kind;
                n_code = r_code;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (emit) begin
            n_ov = 1'b1;
        end else if (!i_stall) begin
            n_ov = 1'b0;
        end
        n_pend = emit ? rest : r_pend;
        if (o_pop) begin
            n_pend = {(i_pkt.dx != 11'sd0) || (i_pkt.dy != 11'sd0),
                      i_pkt.wz != 3'sd0,
                      i_pkt.right != r_right,
                      i_pkt.left != r_left};
        end
    end

    // Output payload takes the cursor before a same-cycle pop updates it.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= n_kind;
            r_code <= n_code;
            r_owz  <= n_owz;
            r_last <= n_last;
            r_px   <= ps2mt_pkg::to_ptr(r_cx);
            r_py   <= ps2mt_pkg::to_ptr(r_cy);
        end
        if (o_pop) begin
            r_wz <= i_pkt.wz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= ps2mt_pkg::ResetX;
            r_cy    <= ps2mt_pkg::ResetY;
            r_left  <= 1'b0;
            r_right <= 1'b0;
            r_pend  <= 4'd0;
            r_ov    <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_ov   <= n_ov;
            if (o_pop) begin
                r_cx    <= ps2mt_pkg::clamp_coord(r_cx, i_pkt.dx, i_cfg.width_limit);
                r_cy    <= ps2mt_pkg::clamp_coord(r_cy, i_pkt.dy, i_cfg.height_limit);
                r_left  <= i_pkt.left;
                r_right <= i_pkt.right;
            end
        end
    end

    assign o_valid          = r_ov;
    assign o_event_kind     = r_kind;
    assign o_button_code    = r_code;
    assign o_pointer_x      = r_px;
    assign o_pointer_y      = r_py;
    assign o_wheel_delta    = r_owz;
    assign o_last_of_packet = r_last;

endmodule

`default_nettype wire

[design/ps2_mouse_packet_tracker.sv]
// Top level of the PS/2 mouse packet tracker: config registers, front end,
// packet queue and back end. Uses ps2mt_pkg, ps2mt_front, ps2mt_fifo, ps2mt_back.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------
//   input    | in        | i_valid / o_stall  | i_rx_byte
//   output   | out       | o_valid / i_stall  | o_event_kind .. o_last_of_packet
//   config   | in        | APB psel/penable   | paddr, pwdata, prdata
//
// A byte is taken every cycle while the two-entry packet queue has room.
// The back end issues a packet's events (1 to 4) one at a time, overlapped
// with loading the next one; a packet with no events is popped without any.
// Reset is synchronous and active low: restores registers, cursor 320/240.
// A stalled output holds its beat; the queue fills, then the input stalls.
`default_nettype none

module ps2_mouse_packet_tracker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_event_kind,
    output logic [1:0]       o_button_code,
    output logic [11:0]      o_pointer_x,
    output logic [11:0]      o_pointer_y,
    output logic signed [2:0] o_wheel_delta,
    output logic             o_last_of_packet,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ps2mt_pkg::t_cfg r_cfg;
    ps2mt_pkg::t_reg reg_idx;
    logic            cfg_wr;

    logic            push, pop, full, empty;
    ps2mt_pkg::t_pkt f_pkt, q_pkt;

    assign pready  = 1'b1;
    assign reg_idx = ps2mt_pkg::t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_mode   <= 1'b0;
            r_cfg.width_limit  <= 13'd640;
            r_cfg.height_limit <= 13'd480;
            r_cfg.speed_factor <= 2'd2;
        end else if (cfg_wr) begin
            case (reg_idx)
                ps2mt_pkg::RegWheelMode:   r_cfg.wheel_mode   <= pwdata[0];
                ps2mt_pkg::RegWidthLimit:  r_cfg.width_limit  <= pwdata[12:0];
                ps2mt_pkg::RegHeightLimit: r_cfg.height_limit <= pwdata[12:0];
                ps2mt_pkg::RegSpeedFactor: r_cfg.speed_factor <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ps2mt_pkg::RegWheelMode:   prdata = {31'd0, r_cfg.wheel_mode};
            ps2mt_pkg::RegWidthLimit:  prdata = {19'd0, r_cfg.width_limit};
            ps2mt_pkg::RegHeightLimit: prdata = {19'd0, r_cfg.height_limit};
            ps2mt_pkg::RegSpeedFactor: prdata = {30'd0, r_cfg.speed_factor};
            default:                   prdata = 32'd0;
        endcase
    end

    ps2mt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_push    (push),
        .o_pkt     (f_pkt),
        .i_full    (full)
    );

    ps2mt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (f_pkt),
        .o_full  (full),
        .i_pop   (pop),
        .o_pkt   (q_pkt),
        .o_empty (empty)
    );

    ps2mt_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_pkt            (q_pkt),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_button_code    (o_button_code),
        .o_pointer_x      (o_pointer_x),
        .o_pointer_y      (o_pointer_y),
        .o_wheel_delta    (o_wheel_delta),
        .o_last_of_packet (o_last_of_packet)
    );

    a_wheel_only_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind != ps2mt_pkg::EvScroll) |-> o_wheel_delta == 3'sd0)
        else $error("wheel delta outside a scroll event");

    a_scroll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == ps2mt_pkg::EvScroll)
            |-> (o_wheel_delta != 3'sd0) && (o_wheel_delta != -3'sd4))
        else $error("scroll event with bad delta");

    a_move_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == ps2mt_pkg::EvMove) |-> o_last_of_packet)
        else $error("move event not last of packet");

    a_button_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_event_kind == ps2mt_pkg::EvDown) || (o_event_kind == ps2mt_pkg::EvUp))
            |-> !o_button_code[1])
        else $error("button edge with bad code");

endmodule

`default_nettype wire
